// ----- hw/rtl/pwd_pkg.sv -----
// Package for the peer-wire message deframer.
// Holds the kind codes, type ids, handshake text and the per-byte result struct.
// No dependencies.
`default_nettype none

package pwd_pkg;

  typedef enum logic [3:0] {
    KIND_HANDSHAKE    = 4'd0,
    KIND_KEEPALIVE    = 4'd1,
    KIND_CHOKE        = 4'd2,
    KIND_UNCHOKE      = 4'd3,
    KIND_INTERESTED   = 4'd4,
    KIND_UNINTERESTED = 4'd5,
    KIND_HAVE         = 4'd6,
    KIND_BITFIELD     = 4'd7,
    KIND_REQUEST      = 4'd8,
    KIND_PIECE        = 4'd9,
    KIND_CANCEL       = 4'd10,
    KIND_PORT         = 4'd11,
    KIND_DISCARD      = 4'd12
  } kind_t;

  // Message type ids carried in the first body byte
  localparam logic [7:0] TYPE_CHOKE        = 8'd0;
  localparam logic [7:0] TYPE_UNCHOKE      = 8'd1;
  localparam logic [7:0] TYPE_INTERESTED   = 8'd2;
  localparam logic [7:0] TYPE_UNINTERESTED = 8'd3;
  localparam logic [7:0] TYPE_HAVE         = 8'd4;
  localparam logic [7:0] TYPE_BITFIELD     = 8'd5;
  localparam logic [7:0] TYPE_REQUEST      = 8'd6;
  localparam logic [7:0] TYPE_PIECE        = 8'd7;
  localparam logic [7:0] TYPE_CANCEL       = 8'd8;
  localparam logic [7:0] TYPE_PORT         = 8'd9;

  // Fixed body lengths
  localparam int unsigned LEN_STATE = 1;
  localparam int unsigned LEN_PORT  = 3;
  localparam int unsigned LEN_HAVE  = 5;
  localparam int unsigned LEN_REQ   = 13;

  // Handshake framing
  localparam logic [7:0] HS_LEAD        = 8'd19;
  localparam logic [6:0] HS_HEADER_LAST = 7'd19;
  localparam logic [6:0] HS_FINAL_POS   = 7'd67;
  localparam logic [6:0] POS_SATURATE   = 7'd68;
  localparam logic [6:0] POS_LEN_LAST   = 7'd3;
  localparam logic [6:0] POS_TYPE       = 7'd4;

  // Which fixed lengths the prefix matched
  typedef struct packed {
    logic is_state;
    logic is_port;
    logic is_have;
    logic is_req;
  } len_class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    kind_t      kind;
  } pwd_result_t;

  // Protocol string, character idx (0..18)
  function automatic logic [7:0] hs_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "B";
      5'd1:    c = "i";
      5'd2:    c = "t";
      5'd3:    c = "T";
      5'd4:    c = "o";
      5'd5:    c = "r";
      5'd6:    c = "r";
      5'd7:    c = "e";
      5'd8:    c = "n";
      5'd9:    c = "t";
      5'd10:   c = " ";
      5'd11:   c = "p";
      5'd12:   c = "r";
      5'd13:   c = "o";
      5'd14:   c = "t";
      5'd15:   c = "o";
      5'd16:   c = "c";
      5'd17:   c = "o";
      5'd18:   c = "l";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  // Kind of a non-empty length-prefixed message
  function automatic kind_t body_kind(input logic [7:0] tid, input len_class_t cls);
    kind_t k;
    case (tid)
      TYPE_CHOKE:        k = cls.is_state ? KIND_CHOKE        : KIND_DISCARD;
      TYPE_UNCHOKE:      k = cls.is_state ? KIND_UNCHOKE      : KIND_DISCARD;
      TYPE_INTERESTED:   k = cls.is_state ? KIND_INTERESTED   : KIND_DISCARD;
      TYPE_UNINTERESTED: k = cls.is_state ? KIND_UNINTERESTED : KIND_DISCARD;
      TYPE_HAVE:         k = cls.is_have  ? KIND_HAVE         : KIND_DISCARD;
      TYPE_BITFIELD:     k = KIND_BITFIELD;
      TYPE_REQUEST:      k = cls.is_req   ? KIND_REQUEST      : KIND_DISCARD;
      TYPE_PIECE:        k = KIND_PIECE;
      TYPE_CANCEL:       k = cls.is_req   ? KIND_CANCEL       : KIND_DISCARD;
      TYPE_PORT:         k = cls.is_port  ? KIND_PORT         : KIND_DISCARD;
      default:           k = KIND_DISCARD;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/peer_wire_message_deframer.sv -----
// Peer-wire message deframer, top level: input register, tracker, result register.
// Depends on pwd_pkg and pwd_tracker.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------
//   in      | in_valid / in_stall | stream_byte
//   out     | out_valid/out_stall | data_byte, first_of_message,
//           |                     | last_of_message, message_kind
//
// One item per cycle sustained while the output is not stalled; an accepted byte
// passes through the input register and then the result register. The framing
// state is read and updated between the input register and the result register.
// Reset (rst, synchronous) empties both registers and returns framing to the
// start of a message. With the output stalled, one more item is still taken
// into the input register; after that in_stall rises.
`default_nettype none

module peer_wire_message_deframer
  import pwd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] stream_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      data_byte,
  output logic            first_of_message,
  output logic            last_of_message,
  output logic [3:0]      message_kind
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_advance;
  logic        step;
  pwd_result_t result;

  // Advance the input register whenever the result register is free or being taken
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign step       = s1_valid && s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte <= stream_byte;
    end
  end

  pwd_tracker #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .byte_in(s1_byte),
    .result (result)
  );

  // Result register: hold while stalled, load the next item otherwise
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_byte        <= result.data;
      first_of_message <= result.first;
      last_of_message  <= result.last;
      message_kind     <= result.kind;
    end
  end

  // A message is never shorter than four bytes
  a_first_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(first_of_message && last_of_message))
    else $error("first and last mark on the same item");

  // Kind stays zero away from the last byte
  a_kind_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_message |-> message_kind == KIND_HANDSHAKE)
    else $error("kind set on a byte that does not end a message");

  // Back-pressure only when both registers are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result register could move");

  // A message that just ended is followed by a starting one
  a_start_after_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_of_message ##1 out_valid |-> first_of_message)
    else $error("item after a message end is not marked first");

endmodule

`default_nettype wire

// ----- hw/rtl/pwd_tracker.sv -----
// Message tracker: framing state and per-byte marks and kind.
// Depends on pwd_pkg.
`default_nettype none

module pwd_tracker
  import pwd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  output pwd_result_t      result
);

  localparam logic [32:0] LENGTH_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

  logic [6:0]             pos;
  logic [6:0]             pos_next;
  logic                   hs_match;
  logic                   hs_now;
  logic [23:0]            len_hi;
  logic [LENGTH_BITS-1:0] remaining;
  logic [LENGTH_BITS-1:0] len_now;
  logic [32:0]            len_full;
  len_class_t             len_cls;
  len_class_t             cls_now;
  logic [7:0]             type_id;
  logic [7:0]             tid_now;
  logic                   last;
  kind_t                  kind;

  always_comb begin
    if (pos == '0) begin
      hs_now = (byte_in == HS_LEAD);
    end else if (pos <= HS_HEADER_LAST) begin
      hs_now = hs_match && (byte_in == hs_char(5'(pos - 7'd1)));
    end else begin
      hs_now = hs_match;
    end

    // Saturate an oversized prefix to the widest supported length
    len_full = {1'b0, len_hi, byte_in};
    len_now  = (len_full > LENGTH_MAX) ? LENGTH_MAX[LENGTH_BITS-1:0]
                                       : len_full[LENGTH_BITS-1:0];
    cls_now.is_state = (len_now == LENGTH_BITS'(LEN_STATE));
    cls_now.is_port  = (len_now == LENGTH_BITS'(LEN_PORT));
    cls_now.is_have  = (len_now == LENGTH_BITS'(LEN_HAVE));
    cls_now.is_req   = (len_now == LENGTH_BITS'(LEN_REQ));

    tid_now = (pos == POS_TYPE) ? byte_in : type_id;

    if (hs_now) begin
      last = (pos == HS_FINAL_POS);
      kind = KIND_HANDSHAKE;
    end else if (pos == POS_LEN_LAST) begin
      last = (len_now == '0);
      kind = KIND_KEEPALIVE;
    end else begin
      last = (pos > POS_LEN_LAST) && (remaining == '0);
      kind = body_kind(tid_now, len_cls);
    end

    if (last) begin
      pos_next = '0;
    end else if (pos == POS_SATURATE) begin
      pos_next = pos;
    end else begin
      pos_next = pos + 7'd1;
    end

    result.data  = byte_in;
    result.first = (pos == '0);
    result.last  = last;
    result.kind  = last ? kind : KIND_HANDSHAKE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      hs_match <= 1'b0;
    end else if (step) begin
      pos      <= pos_next;
      hs_match <= last ? 1'b0 : hs_now;
    end
  end

  // Payload state: overwritten at its own byte of every message before use
  always_ff @(posedge clk) begin
    if (step) begin
      if (pos == '0) begin
        len_hi <= {16'd0, byte_in};
      end else if (pos < POS_LEN_LAST) begin
        len_hi <= {len_hi[15:0], byte_in};
      end
      if (pos == POS_LEN_LAST) begin
        remaining <= len_now - LENGTH_BITS'(1);
        len_cls   <= cls_now;
      end else if (pos > POS_LEN_LAST) begin
        remaining <= remaining - LENGTH_BITS'(1);
      end
      if (pos == POS_TYPE) begin
        type_id <= byte_in;
      end
    end
  end

endmodule

`default_nettype wire
